FILE: rtl/c_subset_token_scanner_assert.svh
// Assertion macros used by the scanner top level.
`ifndef C_SUBSET_TOKEN_SCANNER_ASSERT_SVH
`define C_SUBSET_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, checked out of reset.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and lookup functions of the C subset token scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam logic [7:0] MAX_TOKEN_LENGTH = 8'd255;
  localparam logic [7:0] STAR_CAP         = 8'd254;
  localparam logic [7:0] LEN_CAP          = 8'd255;
  localparam logic [7:0] FRAC_CAP         = 8'd255;
  localparam int         NUM_KW           = 14;
  localparam int         Q_DEPTH          = 4;
  localparam logic [62:0] VALUE_MAX       = {63{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [2:0] CLS_CONTROL  = 3'd0;
  localparam logic [2:0] CLS_TYPE     = 3'd1;
  localparam logic [2:0] CLS_GROUP    = 3'd2;
  localparam logic [2:0] CLS_LITERAL  = 3'd3;
  localparam logic [2:0] CLS_OPERATOR = 3'd4;
  localparam logic [2:0] CLS_IDENT    = 3'd5;
  localparam logic [2:0] CLS_END      = 3'd6;

  localparam logic [5:0] KIND_LAST_GROUP = 6'd22;
  localparam logic [5:0] KIND_INT_LIT    = 6'd23;
  localparam logic [5:0] KIND_FLOAT_LIT  = 6'd24;
  localparam logic [5:0] KIND_CHAR_LIT   = 6'd25;
  localparam logic [5:0] KIND_NONE       = 6'd39;
  localparam logic [5:0] KIND_INVALID    = 6'd63;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LITERAL   = 3'd1;
  localparam logic [2:0] ERR_START     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE    = 3'd3;
  localparam logic [2:0] ERR_CHAR_LIT  = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_INT, MODE_FRAC,
    MODE_STARS, MODE_QOPEN, MODE_QBODY, MODE_QESC
  } mode_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [5:0]  kind;
    logic [62:0] value;
    logic [7:0]  frac;
    logic [7:0]  ptr;
    logic [7:0]  len;
    logic [2:0]  err;
    logic        sat;
    logic        last;
  } result_t;

  function automatic result_t mk_res(logic [2:0] cls, logic [5:0] kind, logic [62:0] value,
                                     logic [7:0] frac, logic [7:0] ptr, logic [7:0] len,
                                     logic [2:0] err, logic sat);
    result_t r;
    r.cls = cls; r.kind = kind; r.value = value; r.frac = frac; r.ptr = ptr;
    r.len = len; r.err = err; r.sat = sat; r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_err(logic [7:0] len, logic [2:0] err);
    return mk_res(CLS_CONTROL, KIND_NONE, '0, '0, '0, len, err, 1'b0);
  endfunction

  function automatic logic [7:0] len_inc(logic [7:0] v, logic [7:0] cap);
    return (v < cap) ? v + 8'd1 : cap;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Keyword text, last character in the low byte.
  function automatic logic [55:0] kw_text(logic [3:0] k);
    case (k)
      4'd0:  return 56'("if");
      4'd1:  return 56'("else");
      4'd2:  return 56'("goto");
      4'd3:  return 56'("return");
      4'd4:  return 56'("while");
      4'd5:  return 56'("switch");
      4'd6:  return 56'("case");
      4'd7:  return 56'("default");
      4'd8:  return 56'("break");
      4'd9:  return 56'("int");
      4'd10: return 56'("long");
      4'd11: return 56'("char");
      4'd12: return 56'("float");
      4'd13: return 56'("void");
      default: return '0;
    endcase
  endfunction

  function automatic logic [7:0] kw_len(logic [3:0] k);
    case (k)
      4'd0:                         return 8'd2;
      4'd9:                         return 8'd3;
      4'd1, 4'd2, 4'd6, 4'd10,
      4'd11, 4'd13:                 return 8'd4;
      4'd4, 4'd8, 4'd12:            return 8'd5;
      4'd3, 4'd5:                   return 8'd6;
      4'd7:                         return 8'd7;
      default:                      return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] kw_kind(logic [3:0] k);
    case (k)
      4'd9:    return 6'd10;
      4'd10:   return 6'd11;
      4'd11:   return 6'd12;
      4'd12:   return 6'd13;
      4'd13:   return 6'd15;
      default: return {2'b00, k};
    endcase
  endfunction

  function automatic logic kw_is_type(logic [3:0] k);
    return k >= 4'd9;
  endfunction

  // Character of keyword k at position pos; caller keeps pos below the length.
  function automatic logic [7:0] kw_char(logic [3:0] k, logic [7:0] pos);
    logic [7:0]  back;
    logic [55:0] w;
    back = kw_len(k) - 8'd1 - pos;
    w    = kw_text(k) >> {back[2:0], 3'b000};
    return w[7:0];
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    case (c)
      "(": return 6'd16;  ")": return 6'd17;  ":": return 6'd18;
      "{": return 6'd19;  "}": return 6'd20;  ",": return 6'd21;
      ";": return 6'd22;  "+": return 6'd26;  "-": return 6'd27;
      "*": return 6'd28;  "/": return 6'd29;  "%": return 6'd30;
      "~": return 6'd31;  ".": return 6'd32;  ">": return 6'd33;
      "<": return 6'd34;  "&": return 6'd35;  "|": return 6'd36;
      "^": return 6'd37;  "=": return 6'd38;
      default: return KIND_INVALID;
    endcase
  endfunction

  // Escape value; bit 8 set marks an unknown escape.
  function automatic logic [8:0] escape_value(logic [7:0] c);
    case (c)
      "t":  return 9'd9;
      "b":  return 9'd8;
      "n":  return 9'd10;
      "r":  return 9'd13;
      "f":  return 9'd12;
      8'h27: return 9'h027;
      8'h22: return 9'h022;
      8'h5C: return 9'h05C;
      default: return 9'h100;
    endcase
  endfunction

endpackage

FILE: rtl/cst_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_core
// Scanner state and the per-character step: up to two results per character.
// ----------------------------------------------------------------------------
module cst_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       char_code,
  output cst_pkg::result_t res0,
  output cst_pkg::result_t res1,
  output logic [1:0]       res_cnt
);
  import cst_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [7:0]         run_r, run_nxt;
  logic [62:0]        acc_r, acc_nxt;
  logic [7:0]         frac_r, frac_nxt;
  logic [NUM_KW-1:0]  cand_r, cand_nxt;
  logic [7:0]         star_r, star_nxt;
  logic [7:0]         qch_r, qch_nxt;
  logic               clamp_r, clamp_nxt;

  logic [NUM_KW-1:0]  match;
  logic [NUM_KW-1:0]  first_match_v;
  logic               hit_v;
  logic [3:0]         hit_k;
  logic [5:0]         star_kind;
  logic [66:0]        prod;
  logic [8:0]         esc;
  logic [5:0]         sk;
  logic               a_v, b_v, taken;
  result_t            a_res, b_res;

  // Keyword filters and the word-end hit.
  always_comb begin
    hit_v     = 1'b0;
    hit_k     = '0;
    star_kind = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      match[k] = (run_r < kw_len(4'(k))) && (kw_char(4'(k), run_r) == char_code);
      first_match_v[k] = kw_char(4'(k), 8'd0) == char_code;
      if (cand_r[k] && kw_len(4'(k)) == run_r) begin
        hit_v = 1'b1;
        hit_k = 4'(k);
      end
      if (cand_r[k]) star_kind = kw_kind(4'(k));
    end
  end

  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 67'(char_code - "0");
  assign esc  = escape_value(char_code);
  assign sk   = single_kind(char_code);

  always_comb begin
    mode_nxt  = mode_r;  run_nxt  = run_r;  acc_nxt  = acc_r;   frac_nxt  = frac_r;
    cand_nxt  = cand_r;  star_nxt = star_r; qch_nxt  = qch_r;   clamp_nxt = clamp_r;
    a_v = 1'b0; a_res = '0; b_v = 1'b0; b_res = '0; taken = 1'b1;

    case (mode_r)
      MODE_WORD: begin
        if (is_word(char_code)) begin
          cand_nxt = cand_r & match;
          run_nxt  = len_inc(run_r, MAX_TOKEN_LENGTH);
        end else begin
          mode_nxt = MODE_IDLE;
          taken    = 1'b0;
          a_v      = 1'b1;
          if (run_r >= MAX_TOKEN_LENGTH) begin
            a_res = mk_err(run_r, ERR_TOO_LONG);
          end else if (clamp_r) begin
            a_res = mk_err(run_r, ERR_LITERAL);
          end else if (hit_v && kw_is_type(hit_k)) begin
            if (char_code == CH_STAR) begin
              a_v      = 1'b0;
              taken    = 1'b1;
              mode_nxt = MODE_STARS;
              cand_nxt = NUM_KW'(1) << hit_k;
              star_nxt = 8'd1;
              run_nxt  = len_inc(run_r, LEN_CAP);
            end else begin
              a_res = mk_res(CLS_TYPE, kw_kind(hit_k), '0, '0, '0, run_r, ERR_NONE, 1'b0);
            end
          end else if (hit_v) begin
            a_res = mk_res(CLS_CONTROL, kw_kind(hit_k), '0, '0, '0, run_r, ERR_NONE, 1'b0);
          end else begin
            a_res = mk_res(CLS_IDENT, KIND_NONE, '0, '0, '0, run_r, ERR_NONE, 1'b0);
          end
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (is_digit(char_code)) begin
          if (prod[66:63] != 4'd0) begin
            acc_nxt   = VALUE_MAX;
            clamp_nxt = 1'b1;
          end else begin
            acc_nxt = prod[62:0];
          end
          if (mode_r == MODE_FRAC) frac_nxt = len_inc(frac_r, FRAC_CAP);
          run_nxt = len_inc(run_r, MAX_TOKEN_LENGTH);
        end else if (char_code == CH_DOT && mode_r == MODE_INT) begin
          mode_nxt = MODE_FRAC;
          run_nxt  = len_inc(run_r, MAX_TOKEN_LENGTH);
        end else if (is_alpha(char_code) || char_code == CH_UNDER || char_code == CH_DOT) begin
          mode_nxt  = MODE_WORD;
          cand_nxt  = '0;
          clamp_nxt = 1'b1;
          run_nxt   = len_inc(run_r, MAX_TOKEN_LENGTH);
        end else begin
          mode_nxt = MODE_IDLE;
          taken    = 1'b0;
          a_v      = 1'b1;
          if (run_r >= MAX_TOKEN_LENGTH) begin
            a_res = mk_err(run_r, ERR_TOO_LONG);
          end else begin
            a_res = mk_res(CLS_LITERAL,
                           (mode_r == MODE_FRAC) ? KIND_FLOAT_LIT : KIND_INT_LIT, acc_r,
                           (mode_r == MODE_FRAC) ? frac_r : 8'd0, '0, run_r, ERR_NONE,
                           clamp_r);
          end
        end
      end
      MODE_STARS: begin
        if (char_code == CH_STAR) begin
          star_nxt = len_inc(star_r, STAR_CAP);
          run_nxt  = len_inc(run_r, LEN_CAP);
        end else begin
          a_v      = 1'b1;
          a_res    = mk_res(CLS_TYPE, star_kind, '0, '0, star_r, run_r, ERR_NONE, 1'b0);
          mode_nxt = MODE_IDLE;
          taken    = 1'b0;
        end
      end
      MODE_QOPEN: begin
        if (char_code == CH_NUL) begin
          a_v = 1'b1; a_res = mk_err(run_r, ERR_CHAR_LIT); mode_nxt = MODE_IDLE; taken = 1'b0;
        end else if (char_code == CH_BSLASH) begin
          mode_nxt = MODE_QESC; run_nxt = 8'd2;
        end else if (char_code == CH_QUOTE) begin
          a_v = 1'b1; a_res = mk_err(8'd2, ERR_CHAR_LIT); mode_nxt = MODE_IDLE;
        end else begin
          qch_nxt = char_code; mode_nxt = MODE_QBODY; run_nxt = 8'd2;
        end
      end
      MODE_QESC: begin
        if (char_code == CH_NUL) begin
          a_v = 1'b1; a_res = mk_err(run_r, ERR_CHAR_LIT); mode_nxt = MODE_IDLE; taken = 1'b0;
        end else begin
          if (esc[8]) begin
            clamp_nxt = 1'b1; qch_nxt = '0;
          end else begin
            qch_nxt = esc[7:0];
          end
          mode_nxt = MODE_QBODY;
          run_nxt  = 8'd3;
        end
      end
      MODE_QBODY: begin
        a_v      = 1'b1;
        mode_nxt = MODE_IDLE;
        if (char_code == CH_QUOTE) begin
          run_nxt = len_inc(run_r, LEN_CAP);
          if (clamp_r) a_res = mk_err(run_nxt, ERR_ESCAPE);
          else a_res = mk_res(CLS_LITERAL, KIND_CHAR_LIT, 63'(qch_r), '0, '0, run_nxt,
                              ERR_NONE, 1'b0);
        end else begin
          a_res = mk_err(run_r, ERR_CHAR_LIT);
          taken = 1'b0;
        end
      end
      default: taken = 1'b0;
    endcase

    // Start a new token with this character.
    if (!taken) begin
      mode_nxt = MODE_IDLE; run_nxt = 8'd1; acc_nxt = '0; frac_nxt = '0;
      cand_nxt = '0; star_nxt = '0; qch_nxt = '0; clamp_nxt = 1'b0;
      if (char_code == CH_NUL) begin
        run_nxt = '0;
        b_v = 1'b1; b_res = mk_res(CLS_END, KIND_NONE, '0, '0, '0, '0, ERR_NONE, 1'b0);
      end else if (is_space(char_code)) begin
        run_nxt = '0;
      end else if (sk != KIND_INVALID) begin
        b_v   = 1'b1;
        b_res = mk_res((sk <= KIND_LAST_GROUP) ? CLS_GROUP : CLS_OPERATOR, sk, '0, '0, '0,
                       8'd1, ERR_NONE, 1'b0);
      end else if (char_code == CH_QUOTE) begin
        mode_nxt = MODE_QOPEN;
      end else if (is_alpha(char_code) || char_code == CH_UNDER) begin
        mode_nxt = MODE_WORD;
        cand_nxt = first_match_v;
      end else if (is_digit(char_code)) begin
        mode_nxt = MODE_INT;
        acc_nxt  = 63'(char_code - "0");
      end else begin
        b_v = 1'b1; b_res = mk_err(8'd1, ERR_START);
      end
    end

    // Pack results, mark the final one of this character.
    res0    = a_v ? a_res : b_res;
    res1    = b_res;
    res_cnt = {1'b0, a_v} + {1'b0, b_v};
    if (a_v && b_v) res1.last = 1'b1;
    else            res0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE; run_r <= '0; acc_r <= '0; frac_r <= '0;
      cand_r <= '0; star_r <= '0; qch_r <= '0; clamp_r <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt; run_r <= run_nxt; acc_r <= acc_nxt; frac_r <= frac_nxt;
      cand_r <= cand_nxt; star_r <= star_nxt; qch_r <= qch_nxt; clamp_r <= clamp_nxt;
    end
  end

endmodule

FILE: rtl/cst_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_outq
// Small result queue: takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module cst_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  cst_pkg::result_t d0,
  input  cst_pkg::result_t d1,
  input  logic             pop,
  output logic             q_valid,
  output cst_pkg::result_t q_data,
  output logic [2:0]       q_cnt
);
  import cst_pkg::*;

  result_t     mem_r [Q_DEPTH];
  logic [1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        do_pop;

  assign q_valid = cnt_r != 3'd0;
  assign q_data  = mem_r[rp_r];
  assign q_cnt   = cnt_r;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r + push_cnt;
    rp_nxt  = rp_r + {1'b0, do_pop};
    cnt_nxt = cnt_r + {1'b0, push_cnt} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= d0;
    if (push_cnt == 2'd2) mem_r[wp_r + 2'd1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/c_subset_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Character-stream lexer for a C subset: keywords, typed pointers, names,
// integer/float/char literals, marks and error tokens.
// ----------------------------------------------------------------------------
// Channel  Dir  Word                                   Marks
// in_      in   tdata[7:0] char_code                   -
// out_     out  tdata: kind,value,frac,ptr,len,err,sat tuser class, tlast last
//
// One character a cycle: the input register feeds the step logic, whose one
// or two results enter a four-word queue in the same cycle. A character
// giving two results takes two output words, so the output port sets the
// long-run rate. The step waits while the queue holds more than two words.
// Reset (rst_n low, synchronous) empties both stages and returns to idle.
// ----------------------------------------------------------------------------
module c_subset_token_scanner (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_code
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [5:0] token_kind, [68:6] literal_value,
                                   // [76:69] fraction_digits, [84:77] pointer_depth,
                                   // [92:85] token_length, [95:93] error_code,
                                   // [96] value_saturated, rest zero
  output logic [2:0]   out_tuser,  // [2:0] token_class
  output logic         out_tlast   // is_last
);
  import cst_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       fire;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  logic [2:0] q_cnt;
  result_t    res0, res1, q_data;

  // Step when a character waits and the queue has room for two words.
  assign fire      = in_valid_r && (q_cnt <= 3'(Q_DEPTH - 2));
  assign in_tready = !in_valid_r || fire;
  assign push_cnt  = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Hold the character until the step takes it.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_char_r <= in_tdata;
  end

  cst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (fire),
    .char_code (in_char_r),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  cst_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .d0       (res0),
    .d1       (res1),
    .pop      (out_tready),
    .q_valid  (out_tvalid),
    .q_data   (q_data),
    .q_cnt    (q_cnt)
  );

  assign out_tuser = q_data.cls;
  assign out_tlast = q_data.last;
  assign out_tdata = {7'd0, q_data.sat, q_data.err, q_data.len, q_data.ptr,
                      q_data.frac, q_data.value, q_data.kind};

`include "c_subset_token_scanner_assert.svh"

  // Never step into a queue without room for a full pair.
  `CST_ASSERT_NOW(a_room, clk, rst_n, fire, q_cnt <= 3'(Q_DEPTH - 2))
  // End of text always closes with the end marker.
  `CST_ASSERT_NOW(a_eot, clk, rst_n, fire && in_char_r == CH_NUL && res_cnt == 2'd1,
                  res0.cls == CLS_END)
  // A pair carries the last mark on its second word only.
  `CST_ASSERT_NOW(a_pair, clk, rst_n, fire && res_cnt == 2'd2, res1.last && !res0.last)
  // An empty queue stays empty while nothing is pushed.
  `CST_ASSERT_NEXT(a_fill, clk, rst_n, !fire && !out_tvalid, q_cnt == 3'd0)

endmodule

FILE: dv/tb_c_subset_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_subset_token_scanner
// Self-checking testbench for the C subset token scanner. A scoreboard runs
// its own lexer over every accepted character and compares each output word
// against the oldest expected token. Stimulus is a short directed text, then
// random token streams with random stalls on both channels, a long receiver
// hold-off and a run of oversized tokens.
// ----------------------------------------------------------------------------
import cst_pkg::*;

typedef enum int {
  KD_IF, KD_ELSE, KD_GOTO, KD_RETURN, KD_WHILE, KD_SWITCH, KD_CASE, KD_DEFAULT,
  KD_BREAK, KD_UNSIGNED, KD_INT, KD_LONG, KD_CHAR, KD_FLOAT, KD_BOOL, KD_VOID,
  KD_LPAREN, KD_RPAREN, KD_COLON, KD_LBRACE, KD_RBRACE, KD_COMMA, KD_SEMI,
  KD_INT_LIT, KD_FLOAT_LIT, KD_CHAR_LIT, KD_PLUS, KD_MINUS, KD_STAR, KD_SLASH,
  KD_PERCENT, KD_TILDE, KD_DOT, KD_GT, KD_LT, KD_AMP, KD_PIPE, KD_CARET,
  KD_ASSIGN, KD_NONE
} kind_e;

typedef struct {
  logic [2:0]  cls;
  logic [5:0]  kind;
  logic [62:0] value;
  logic [7:0]  frac;
  logic [7:0]  ptr;
  logic [7:0]  len;
  logic [2:0]  err;
  logic        sat;
  logic        last;
} token_t;

class token_scoreboard;
  token_t      token_q[$];
  int          mismatches;
  int          tokens_seen;
  string       kw_word[14];
  kind_e       kw_code[14];
  bit          kw_typed[14];
  mode_t       mode;
  logic [7:0]  run_len, frac_cnt, stars, qchar;
  logic [63:0] acc;
  logic [13:0] cand;
  bit          taint;

  function new();
    kw_word  = '{"if", "else", "goto", "return", "while", "switch", "case", "default",
                 "break", "int", "long", "char", "float", "void"};
    kw_code  = '{KD_IF, KD_ELSE, KD_GOTO, KD_RETURN, KD_WHILE, KD_SWITCH, KD_CASE,
                 KD_DEFAULT, KD_BREAK, KD_INT, KD_LONG, KD_CHAR, KD_FLOAT, KD_VOID};
    kw_typed = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1};
    mode = MODE_IDLE;
    run_len = 0; frac_cnt = 0; stars = 0; qchar = 0; acc = 0; cand = 0; taint = 0;
  endfunction

  function logic [7:0] sat_inc(logic [7:0] v, logic [7:0] cap);
    return (v < cap) ? v + 8'd1 : cap;
  endfunction

  function bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void push(logic [2:0] cls, int kind, logic [62:0] val, logic [7:0] frac,
                     logic [7:0] ptr, logic [7:0] len, logic [2:0] err, logic sat);
    token_t t;
    t.cls = cls; t.kind = kind[5:0]; t.value = val; t.frac = frac; t.ptr = ptr;
    t.len = len; t.err = err; t.sat = sat; t.last = 1'b0;
    token_q.push_back(t);
  endfunction

  function void push_err(logic [7:0] len, logic [2:0] err);
    push(CLS_CONTROL, KD_NONE, '0, '0, '0, len, err, 1'b0);
    mode = MODE_IDLE;
  endfunction

  // Drop keyword candidates that do not have c at the current position.
  function void narrow(logic [7:0] c);
    for (int k = 0; k < 14; k++) begin
      if (cand[k] && (run_len >= kw_word[k].len() || kw_word[k][run_len] != c))
        cand[k] = 1'b0;
    end
  endfunction

  function int mark_kind(logic [7:0] c);
    case (c)
      "(": return KD_LPAREN;  ")": return KD_RPAREN;  ":": return KD_COLON;
      "{": return KD_LBRACE;  "}": return KD_RBRACE;  ",": return KD_COMMA;
      ";": return KD_SEMI;    "+": return KD_PLUS;    "-": return KD_MINUS;
      "*": return KD_STAR;    "/": return KD_SLASH;   "%": return KD_PERCENT;
      "~": return KD_TILDE;   ".": return KD_DOT;     ">": return KD_GT;
      "<": return KD_LT;      "&": return KD_AMP;     "|": return KD_PIPE;
      "^": return KD_CARET;   "=": return KD_ASSIGN;
      default: return -1;
    endcase
  endfunction

  // Escaped character value, -1 for an escape the lexer does not know.
  function int esc_char(logic [7:0] c);
    case (c)
      "t": return 9;  "b": return 8;  "n": return 10; "r": return 13; "f": return 12;
      CH_QUOTE, 8'h22, CH_BSLASH: return c;
      default: return -1;
    endcase
  endfunction

  function void add_digit(logic [7:0] c);
    logic [63:0] d, vmax;
    d = 64'(c - "0");
    vmax = {1'b0, VALUE_MAX};
    if (acc > (vmax - d) / 10) begin
      acc = vmax;
      taint = 1'b1;
    end else begin
      acc = acc * 10 + d;
    end
  endfunction

  // Close a word; returns 1 when c is swallowed as the first pointer star.
  function bit close_word(logic [7:0] c);
    int hit;
    hit = -1;
    mode = MODE_IDLE;
    if (run_len >= MAX_TOKEN_LENGTH) begin
      push_err(run_len, ERR_TOO_LONG);
      return 0;
    end
    if (taint) begin
      push_err(run_len, ERR_LITERAL);
      return 0;
    end
    for (int k = 0; k < 14; k++)
      if (cand[k] && kw_word[k].len() == run_len) hit = k;
    if (hit >= 0 && kw_typed[hit]) begin
      if (c == CH_STAR) begin
        mode = MODE_STARS;
        cand = 14'd1 << hit;
        stars = 8'd1;
        run_len = sat_inc(run_len, LEN_CAP);
        return 1;
      end
      push(CLS_TYPE, kw_code[hit], '0, '0, '0, run_len, ERR_NONE, 1'b0);
    end else if (hit >= 0) begin
      push(CLS_CONTROL, kw_code[hit], '0, '0, '0, run_len, ERR_NONE, 1'b0);
    end else begin
      push(CLS_IDENT, KD_NONE, '0, '0, '0, run_len, ERR_NONE, 1'b0);
    end
    return 0;
  endfunction

  function void close_number(bit is_float);
    mode = MODE_IDLE;
    if (run_len >= MAX_TOKEN_LENGTH) begin
      push_err(run_len, ERR_TOO_LONG);
      return;
    end
    push(CLS_LITERAL, is_float ? KD_FLOAT_LIT : KD_INT_LIT, acc[62:0],
         is_float ? frac_cnt : 8'd0, '0, run_len, ERR_NONE, taint);
  endfunction

  function void open_token(logic [7:0] c);
    int mk;
    mk = mark_kind(c);
    mode = MODE_IDLE;
    run_len = 8'd1; acc = 0; frac_cnt = 0; cand = 0; stars = 0; qchar = 0; taint = 0;
    if (c == CH_NUL) begin
      run_len = 0;
      push(CLS_END, KD_NONE, '0, '0, '0, '0, ERR_NONE, 1'b0);
    end else if (c == " " || (c >= 9 && c <= 13)) begin
      run_len = 0;
    end else if (mk >= 0) begin
      push(mk <= KD_SEMI ? CLS_GROUP : CLS_OPERATOR, mk, '0, '0, '0, 8'd1, ERR_NONE, 1'b0);
    end else if (c == CH_QUOTE) begin
      mode = MODE_QOPEN;
    end else if (letter(c) || c == CH_UNDER) begin
      mode = MODE_WORD;
      cand = '1;
      run_len = 0;
      narrow(c);
      run_len = 8'd1;
    end else if (digit(c)) begin
      mode = MODE_INT;
      acc = 64'(c - "0");
    end else begin
      push_err(8'd1, ERR_START);
    end
  endfunction

  // Advance the lexer by one accepted character and queue its tokens.
  function void note_char(logic [7:0] c);
    bit taken;
    int n0, e;
    taken = 1;
    n0 = token_q.size();
    case (mode)
      MODE_WORD: begin
        if (letter(c) || digit(c) || c == CH_UNDER) begin
          narrow(c);
          run_len = sat_inc(run_len, MAX_TOKEN_LENGTH);
        end else begin
          taken = close_word(c);
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (digit(c)) begin
          add_digit(c);
          if (mode == MODE_FRAC) frac_cnt = sat_inc(frac_cnt, FRAC_CAP);
          run_len = sat_inc(run_len, MAX_TOKEN_LENGTH);
        end else if (c == CH_DOT && mode == MODE_INT) begin
          mode = MODE_FRAC;
          run_len = sat_inc(run_len, MAX_TOKEN_LENGTH);
        end else if (letter(c) || c == CH_UNDER || c == CH_DOT) begin
          // letters or a second point taint the number into a bad word
          mode = MODE_WORD;
          cand = 0;
          taint = 1'b1;
          run_len = sat_inc(run_len, MAX_TOKEN_LENGTH);
        end else begin
          close_number(mode == MODE_FRAC);
          taken = 0;
        end
      end
      MODE_STARS: begin
        if (c == CH_STAR) begin
          stars = sat_inc(stars, STAR_CAP);
          run_len = sat_inc(run_len, LEN_CAP);
        end else begin
          e = 0;
          for (int k = 0; k < 14; k++) if (cand[k]) e = kw_code[k];
          push(CLS_TYPE, e, '0, '0, stars, run_len, ERR_NONE, 1'b0);
          mode = MODE_IDLE;
          taken = 0;
        end
      end
      MODE_QOPEN: begin
        if (c == CH_NUL) begin
          push_err(run_len, ERR_CHAR_LIT);
          taken = 0;
        end else if (c == CH_BSLASH) begin
          mode = MODE_QESC;
          run_len = 8'd2;
        end else if (c == CH_QUOTE) begin
          push_err(8'd2, ERR_CHAR_LIT);
        end else begin
          qchar = c;
          mode = MODE_QBODY;
          run_len = 8'd2;
        end
      end
      MODE_QESC: begin
        if (c == CH_NUL) begin
          push_err(run_len, ERR_CHAR_LIT);
          taken = 0;
        end else begin
          e = esc_char(c);
          if (e < 0) begin
            taint = 1'b1;
            qchar = 0;
          end else begin
            qchar = e[7:0];
          end
          mode = MODE_QBODY;
          run_len = 8'd3;
        end
      end
      MODE_QBODY: begin
        if (c == CH_QUOTE) begin
          run_len = sat_inc(run_len, LEN_CAP);
          if (taint) push_err(run_len, ERR_ESCAPE);
          else push(CLS_LITERAL, KD_CHAR_LIT, {55'd0, qchar}, '0, '0, run_len,
                    ERR_NONE, 1'b0);
          mode = MODE_IDLE;
        end else begin
          push_err(run_len, ERR_CHAR_LIT);
          taken = 0;
        end
      end
      default: taken = 0;
    endcase
    if (!taken) open_token(c);
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endfunction

  // Compare one output word with the oldest expected token.
  function void check_word(token_t got);
    token_t want;
    tokens_seen++;
    if (token_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected token cls=%0d kind=%0d len=%0d", got.cls, got.kind,
                 got.len);
      return;
    end
    want = token_q.pop_front();
    if (got.cls !== want.cls || got.kind !== want.kind || got.value !== want.value ||
        got.frac !== want.frac || got.ptr !== want.ptr || got.len !== want.len ||
        got.err !== want.err || got.sat !== want.sat || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: token %0d mismatch", tokens_seen);
        $display("  exp cls=%0d kind=%0d val=%0d frac=%0d ptr=%0d len=%0d err=%0d sat=%0d last=%0d",
                 want.cls, want.kind, want.value, want.frac, want.ptr, want.len, want.err,
                 want.sat, want.last);
        $display("  got cls=%0d kind=%0d val=%0d frac=%0d ptr=%0d len=%0d err=%0d sat=%0d last=%0d",
                 got.cls, got.kind, got.value, got.frac, got.ptr, got.len, got.err,
                 got.sat, got.last);
      end
    end
  endfunction
endclass

module tb_c_subset_token_scanner;
  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  token_scoreboard sb;
  int  chars_sent;
  int  rx_hold;        // receiver hold-off request, counted down by the receiver
  bit  tx_steady;      // sender offers back to back
  bit  rx_steady;      // receiver always ready
  int  idle_cycles;

  c_subset_token_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Monitor: feed accepted characters to the lexer, check accepted tokens.
  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata);
      if (out_tvalid && out_tready) begin
        got.cls   = out_tuser;
        got.kind  = out_tdata[5:0];
        got.value = out_tdata[68:6];
        got.frac  = out_tdata[76:69];
        got.ptr   = out_tdata[84:77];
        got.len   = out_tdata[92:85];
        got.err   = out_tdata[95:93];
        got.sat   = out_tdata[96];
        got.last  = out_tlast;
        sb.check_word(got);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("c_subset_token_scanner regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    int gap;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady) gap = pick_gap();
      end
    end
  end

  // Offer one character and hold it until the scanner takes it.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_run(input logic [7:0] c, input int count);
    repeat (count) send_char(c);
  endtask

  // Stop offering, then wait until every expected token has come out.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.token_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  task automatic send_digits(input int count);
    repeat (count) send_char(8'("0" + $urandom_range(0, 9)));
  endtask

  // One random token, well formed most of the time.
  task automatic send_token();
    string marks, escs;
    int r;
    marks = "():{},;+-*/%~.><&|^=";
    escs  = "tbnrf'\"\\";
    r = $urandom_range(0, 99);
    if (r < 18) begin
      // keyword, sometimes with a suffix that turns it into a name
      send_text(sb.kw_word[$urandom_range(0, 13)]);
      if ($urandom_range(0, 5) == 0) send_char(word_char(0));
      if ($urandom_range(0, 2) == 0) send_run(CH_STAR, $urandom_range(1, 3));
    end else if (r < 30) begin
      send_char(word_char(1));
      repeat ($urandom_range(0, 7)) send_char(word_char(0));
    end else if (r < 42) begin
      send_digits($urandom_range(1, 4) == 1 ? $urandom_range(17, 24) : $urandom_range(1, 6));
    end else if (r < 50) begin
      send_digits($urandom_range(1, 5));
      send_char(CH_DOT);
      send_digits($urandom_range(0, 5));
    end else if (r < 62) begin
      send_char(CH_QUOTE);
      case ($urandom_range(0, 5))
        0: send_char(CH_BSLASH);
        1: begin send_char(CH_BSLASH); send_char(escs[$urandom_range(0, 7)]); end
        2: begin send_char(CH_BSLASH); send_char(word_char(1)); end
        3: ;
        default: send_char(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 7) != 0) send_char(CH_QUOTE);
    end else if (r < 80) begin
      send_char(marks[$urandom_range(0, marks.len() - 1)]);
    end else if (r < 86) begin
      // broken number: letter or a second point inside
      send_digits($urandom_range(1, 3));
      if ($urandom_range(0, 1)) send_char(word_char(1));
      else begin send_char(CH_DOT); send_digits(1); send_char(CH_DOT); end
      send_digits($urandom_range(0, 2));
    end else if (r < 95) begin
      send_char(8'($urandom_range(1, 255)));
    end else if (r < 98) begin
      send_char(8'($urandom_range(9, 13)));
    end else begin
      send_char(CH_NUL);
    end
    // separator, or none so that the next token abuts this one
    r = $urandom_range(0, 9);
    if (r < 5) send_char(" ");
    else if (r < 7) send_char(marks[$urandom_range(0, marks.len() - 1)]);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    chars_sent = 0;
    rx_hold = 0;
    tx_steady = 0;
    rx_steady = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keywords with stars, names, literal edges, bad starts, quotes.
    send_text("void**x if_ 9.5 1a 2.3.4 'q''\\n''\\z''' '");
    send_char(8'hFF);
    send_char(8'h80);
    send_char(CH_NUL);

    // Random text with stalls on both sides.
    while (chars_sent < 220) send_token();

    // Receiver holds off while the sender keeps going; the queue fills up.
    rx_hold = 300;
    repeat (40) send_char("+");
    send_text("int a;");
    drain();

    // Back to back on both sides.
    tx_steady = 1;
    rx_steady = 1;
    while (chars_sent < 360) send_token();
    tx_steady = 0;
    rx_steady = 0;
    while (chars_sent < 500) send_token();

    // Oversized tokens: long name, long number, long fraction, many stars.
    send_char(" ");
    send_run("a", 260);
    send_char(" ");
    send_digits(300);
    send_char(";");
    send_char("1");
    send_char(CH_DOT);
    send_digits(300);
    send_char(" ");
    send_text("char");
    send_run(CH_STAR, 260);
    send_char(")");
    send_text("9223372036854775808 ");
    send_char(CH_NUL);

    drain();
    repeat (20) @(posedge clk);

    $display("Scanned %0d characters into %0d tokens: keywords, pointers, names, literals,",
             chars_sent, sb.tokens_seen);
    $display("errors and oversized tokens, with stalls, hold-offs and back-to-back traffic.");
    if (sb.mismatches == 0 && sb.token_q.size() == 0) begin
      $display("c_subset_token_scanner regression: pass");
    end else begin
      $display("c_subset_token_scanner regression: fail");
    end
    $finish;
  end
endmodule
